// ===== rtl/core/tpi_pkg.sv =====
package tpi_pkg;

  // fraction bits of a unit normal component
  localparam int UNIT_BITS = 30;

  // root stages: one result bit per stage
  localparam int SQ_STEPS = 31;
  // unit-normal quotient stages
  localparam int UQ_STEPS = 31;
  // point quotient stages: 31 integer plus 31 fraction bits
  localparam int PQ_STEPS = 62;

  typedef logic signed [15:0] raw_t;
  typedef logic signed [31:0] unit_t;
  typedef logic signed [31:0] dist_t;
  typedef logic signed [63:0] wide_t;

  // side data carried alongside the root stages
  typedef struct packed {
    raw_t [2:0][2:0] raw;
    dist_t [2:0]     dists;
    logic [2:0]      zero;
  } sq_side_t;

  // side data carried alongside the unit-normal quotient stages
  typedef struct packed {
    logic [2:0][2:0] neg;
    logic [2:0]      zero;
    dist_t [2:0]     dists;
  } uq_side_t;

  // side data carried alongside the point quotient stages
  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] sat;
    logic       found;
  } pq_side_t;

endpackage

// ===== rtl/core/tpi_sqrt.sv =====
module tpi_sqrt import tpi_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         l2,
  output logic [SQ_STEPS-1:0] root
);

  localparam int SQ_W = 2 * SQ_STEPS;

  logic [SQ_W-1:0]     rem_q  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_q [SQ_STEPS];

  // one root bit per stage, MSB first; rem holds v - root^2
  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    localparam int I = SQ_STEPS - 1 - s;
    logic [SQ_W-1:0]     rem_in;
    logic [SQ_STEPS-1:0] root_in;
    logic [SQ_W-1:0]     trial;

    if (s == 0) begin : g_first
      assign rem_in  = {l2, {(SQ_W - 32){1'b0}}};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = ({{(SQ_W - SQ_STEPS){1'b0}}, root_in} << (I + 1))
                 | ({{(SQ_W - 1){1'b0}}, 1'b1} << (2 * I));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | ({{(SQ_STEPS - 1){1'b0}}, 1'b1} << I);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root = root_q[SQ_STEPS-1];

endmodule

// ===== rtl/core/tpi_div.sv =====
module tpi_div import tpi_pkg::*; #(
  parameter int DEN_W = 64,
  parameter int STEPS = 62
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [STEPS-1:0] low,
  output logic [STEPS-1:0] quo
);

  logic [DEN_W-1:0] den_q [STEPS];
  logic [DEN_W-1:0] rem_q [STEPS];
  logic [STEPS-1:0] low_q [STEPS];
  logic [STEPS-1:0] quo_q [STEPS];

  // restoring long division, one numerator bit shifted in per stage
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [STEPS-1:0] low_in;
    logic [STEPS-1:0] quo_in;
    logic [DEN_W:0]   cand;

    if (s == 0) begin : g_first
      assign den_in = den;
      assign rem_in = rem_init;
      assign low_in = low;
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign cand = {rem_in, low_in[STEPS-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[s] <= den_in;
        low_q[s] <= {low_in[STEPS-2:0], 1'b0};
        if (cand >= {1'b0, den_in}) begin
          rem_q[s] <= DEN_W'(cand - {1'b0, den_in});
          quo_q[s] <= {quo_in[STEPS-2:0], 1'b1};
        end else begin
          rem_q[s] <= cand[DEN_W-1:0];
          quo_q[s] <= {quo_in[STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[STEPS-1];

endmodule

// ===== rtl/core/three_plane_intersection_core.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    three normals (Q2.14) and distances (Q16.16)
// output    out        out_valid/out_ready  point_x/y/z (Q16.16, saturated), found
//
// Fully pipelined: one item per cycle whenever the pipeline is not stalled.
// Most of the pipeline depth lies in the root stages (31), the unit-normal dividers (31)
// and the point dividers (62), each resolving one bit per stage.
// Reset clears only the valid bits. The pipeline stalls only when the output register
// is full, not taken, and the last stage holds an item; bubbles keep moving otherwise.
module three_plane_intersection_core import tpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] first_normal_x,
  input  logic [15:0] first_normal_y,
  input  logic [15:0] first_normal_z,
  input  logic [31:0] first_dist,
  input  logic [15:0] second_normal_x,
  input  logic [15:0] second_normal_y,
  input  logic [15:0] second_normal_z,
  input  logic [31:0] second_dist,
  input  logic [15:0] third_normal_x,
  input  logic [15:0] third_normal_y,
  input  logic [15:0] third_normal_z,
  input  logic [31:0] third_dist,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z,
  output logic        found
);

  localparam int LAT = 9 + SQ_STEPS + UQ_STEPS + PQ_STEPS;

  logic           en;
  logic [LAT-1:0] vld;

  // global advance, held only when the last item cannot leave
  assign en       = !out_valid || out_ready || !vld[LAT-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // input register
  raw_t [2:0][2:0] raw0;
  dist_t [2:0]     dist0;

  always_ff @(posedge clk) begin
    if (en) begin
      raw0[0][0] <= first_normal_x;
      raw0[0][1] <= first_normal_y;
      raw0[0][2] <= first_normal_z;
      raw0[1][0] <= second_normal_x;
      raw0[1][1] <= second_normal_y;
      raw0[1][2] <= second_normal_z;
      raw0[2][0] <= third_normal_x;
      raw0[2][1] <= third_normal_y;
      raw0[2][2] <= third_normal_z;
      dist0[0]   <= first_dist;
      dist0[1]   <= second_dist;
      dist0[2]   <= third_dist;
    end
  end

  // squared lengths
  logic [31:0] l2 [3];
  logic [31:0] l2_next [3];
  sq_side_t    s1;
  sq_side_t    s1_next;

  always_comb begin
    logic signed [31:0] sq [3];
    s1_next.raw   = raw0;
    s1_next.dists = dist0;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] = $signed(raw0[p][k]) * $signed(raw0[p][k]);
      end
      l2_next[p] = 32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]);
      s1_next.zero[p] = (raw0[p][0] == '0) && (raw0[p][1] == '0) && (raw0[p][2] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        l2[p] <= l2_next[p];
      end
      s1 <= s1_next;
    end
  end

  // lengths
  logic [SQ_STEPS-1:0] root [3];
  sq_side_t            sa [SQ_STEPS];

  for (genvar p = 0; p < 3; p++) begin : g_sqrt
    tpi_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .l2   (l2[p]),
      .root (root[p])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= s1;
      for (int i = 1; i < SQ_STEPS; i++) begin
        sa[i] <= sa[i-1];
      end
    end
  end

  // unit normal magnitudes: |v| * 2^45 / root
  logic [UQ_STEPS-1:0] uq [3][3];
  uq_side_t            ub [UQ_STEPS];
  uq_side_t            ub_next;

  for (genvar p = 0; p < 3; p++) begin : g_unit_p
    for (genvar k = 0; k < 3; k++) begin : g_unit_k
      logic [15:0]         mag;
      logic [UQ_STEPS-1:0] rem0;
      assign mag  = sa[SQ_STEPS-1].raw[p][k][15] ? 16'(-sa[SQ_STEPS-1].raw[p][k])
                                                 : sa[SQ_STEPS-1].raw[p][k];
      assign rem0 = UQ_STEPS'({mag, 14'b0});
      tpi_div #(.DEN_W(SQ_STEPS), .STEPS(UQ_STEPS)) u_div (
        .clk      (clk),
        .en       (en),
        .den      (root[p]),
        .rem_init (rem0),
        .low      ({UQ_STEPS{1'b0}}),
        .quo      (uq[p][k])
      );
    end
  end

  always_comb begin
    ub_next.zero  = sa[SQ_STEPS-1].zero;
    ub_next.dists = sa[SQ_STEPS-1].dists;
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        ub_next.neg[p][k] = sa[SQ_STEPS-1].raw[p][k][15];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ub[0] <= ub_next;
      for (int i = 1; i < UQ_STEPS; i++) begin
        ub[i] <= ub[i-1];
      end
    end
  end

  // signed unit normals
  unit_t [2:0][2:0] un;
  dist_t [2:0]      dist_u;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_u <= ub[UQ_STEPS-1].dists;
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          if (ub[UQ_STEPS-1].zero[p]) begin
            un[p][k] <= '0;
          end else if (ub[UQ_STEPS-1].neg[p][k]) begin
            un[p][k] <= -$signed({1'b0, uq[p][k]});
          end else begin
            un[p][k] <= $signed({1'b0, uq[p][k]});
          end
        end
      end
    end
  end

  // cross products, partial terms; cross c pairs normal c with normal c+1
  // c = 0: n1 x n2, c = 1: n2 x n3, c = 2: n3 x n1
  wide_t [2:0][2:0] prod_p;
  wide_t [2:0][2:0] prod_m;
  unit_t [2:0]      n0_x;
  dist_t [2:0]      dist_x;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_x   <= un[0];
      dist_x <= dist_u;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          prod_p[c][k] <= $signed(un[c][(k == 2) ? 0 : k + 1])
                        * $signed(un[(c == 2) ? 0 : c + 1][(k == 0) ? 2 : k - 1]);
          prod_m[c][k] <= $signed(un[c][(k == 0) ? 2 : k - 1])
                        * $signed(un[(c == 2) ? 0 : c + 1][(k == 2) ? 0 : k + 1]);
        end
      end
    end
  end

  // cross components, rounded to nearest, ties away from zero
  unit_t [2:0][2:0] cr;
  unit_t [2:0]      n0_c;
  dist_t [2:0]      dist_c;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_c   <= n0_x;
      dist_c <= dist_x;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          logic signed [63:0] diff;
          logic [63:0]        dmag;
          logic [63:0]        rmag;
          diff = prod_p[c][k] - prod_m[c][k];
          dmag = diff[63] ? 64'(-diff) : 64'(diff);
          rmag = (dmag + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
          cr[c][k] <= diff[63] ? -$signed(rmag[31:0]) : $signed(rmag[31:0]);
        end
      end
    end
  end

  // determinant and numerator products
  wide_t [2:0]      dp;
  wide_t [2:0][2:0] np;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dp[k] <= $signed(n0_c[k]) * $signed(cr[1][k]);
        for (int j = 0; j < 3; j++) begin
          np[j][k] <= $signed(dist_c[j]) * $signed(cr[(j == 2) ? 0 : j + 1][k]);
        end
      end
    end
  end

  // sums
  wide_t       det;
  wide_t [2:0] num;

  always_ff @(posedge clk) begin
    if (en) begin
      det <= dp[0] + dp[1] + dp[2];
      for (int k = 0; k < 3; k++) begin
        num[k] <= np[0][k] + np[1][k] + np[2][k];
      end
    end
  end

  // magnitudes, signs and the integer-overflow test
  logic [63:0]       dd;
  logic [2:0][63:0]  dn;
  pq_side_t          pd_in;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [63:0] dmag;
      logic [63:0] nmag;
      dmag = det[63] ? 64'(-det) : 64'(det);
      dd   <= dmag;
      pd_in.found <= (det != '0);
      for (int k = 0; k < 3; k++) begin
        nmag = num[k][63] ? 64'(-num[k]) : 64'(num[k]);
        dn[k]          <= nmag;
        pd_in.neg[k]   <= num[k][63] ^ det[63];
        pd_in.sat[k]   <= ({31'b0, nmag[63:31]} >= dmag);
      end
    end
  end

  // point quotients: floor(|num| * 2^31 / |det|)
  logic [PQ_STEPS-1:0] pq [3];
  pq_side_t            pd [PQ_STEPS];

  for (genvar k = 0; k < 3; k++) begin : g_pdiv
    tpi_div #(.DEN_W(64), .STEPS(PQ_STEPS)) u_div (
      .clk      (clk),
      .en       (en),
      .den      (dd),
      .rem_init ({31'b0, dn[k][63:31]}),
      .low      ({dn[k][30:0], 31'b0}),
      .quo      (pq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= pd_in;
      for (int i = 1; i < PQ_STEPS; i++) begin
        pd[i] <= pd[i-1];
      end
    end
  end

  // final rounding and clamp
  logic [2:0][31:0] mr;
  logic [2:0]       neg_r;
  logic             found_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [PQ_STEPS:0]   sum;
      logic [PQ_STEPS-1:0] rq;
      logic [31:0]         lim;
      found_r <= pd[PQ_STEPS-1].found;
      neg_r   <= pd[PQ_STEPS-1].neg;
      for (int k = 0; k < 3; k++) begin
        sum = {1'b0, pq[k]} + {{PQ_STEPS{1'b0}}, 1'b1};
        rq  = sum[PQ_STEPS:1];
        lim = pd[PQ_STEPS-1].neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (pd[PQ_STEPS-1].sat[k] || (rq > {{(PQ_STEPS - 32){1'b0}}, lim})) begin
          mr[k] <= lim;
        end else begin
          mr[k] <= rq[31:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[LAT-1]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAT-1]) begin
      found   <= found_r;
      point_x <= !found_r ? 32'd0 : (neg_r[0] ? 32'(-mr[0]) : mr[0]);
      point_y <= !found_r ? 32'd0 : (neg_r[1] ? 32'(-mr[1]) : mr[1]);
      point_z <= !found_r ? 32'd0 : (neg_r[2] ? 32'(-mr[2]) : mr[2]);
    end
  end

endmodule
